>>> rtl/wasc_pkg.sv
// Shared types and constants for the wildcard attribute score counter.
// Holds the controller/datapath command and status structs and the count width.
// No dependencies.
`default_nettype none

package wasc_pkg;

	// Width and saturation value of the reported match count
	localparam int unsigned COUNT_W = 11;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Action codes of an input transaction
	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;          // capture the input transaction, clear scan state
		logic add;           // append the captured record when room is left
		logic scan_rd;       // read the record at the scan address, advance it
		logic finish_add;    // present the add acknowledgement
		logic finish_query;  // present the query answer
	} wasc_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic scan_end;      // scan address has reached the record total
	} wasc_status_t;

endpackage

`default_nettype wire

>>> rtl/wasc_ctrl.sv
// Controller state machine of the wildcard attribute score counter.
// Sequences adds and record scans; depends on wasc_pkg for command/status types.
`default_nettype none

module wasc_ctrl
	import wasc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic         action,
	input  wire wasc_status_t status,
	output logic              busy,
	output wasc_cmd_t         cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ADD   = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = (action == ACT_QUERY) ? ST_SCAN : ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.add        = 1'b1;
				cmd.finish_add = 1'b1;
				state_d        = ST_IDLE;
			end
			ST_SCAN: begin
				if (status.scan_end) begin
					state_d = ST_DRAIN;
				end else begin
					cmd.scan_rd = 1'b1;
				end
			end
			ST_DRAIN: begin
				// last compare has landed in the count
				cmd.finish_query = 1'b1;
				state_d          = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	// An accepted transaction makes the block busy on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// A finish command always returns the controller to idle
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish_add || cmd.finish_query) |=> !busy)
		else $error("finish did not return to idle");

	// Exactly one state bit is set
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state not one-hot");

endmodule

`default_nettype wire

>>> rtl/wasc_dpath.sv
// Datapath of the wildcard attribute score counter: record memory, record
// total, scan address, match compare and saturating count. Uses wasc_pkg.
`default_nettype none

module wasc_dpath
	import wasc_pkg::*;
#(
	parameter int unsigned MAX_RECORDS = 1024,
	parameter int unsigned KEY_BITS    = 3,
	parameter int unsigned SCORE_BITS  = 20
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire wasc_cmd_t             cmd,
	input  wire logic                  action,
	input  wire logic [KEY_BITS-1:0]   key_first,
	input  wire logic [KEY_BITS-1:0]   key_second,
	input  wire logic [KEY_BITS-1:0]   key_third,
	input  wire logic [KEY_BITS-1:0]   key_fourth,
	input  wire logic [SCORE_BITS-1:0] score_value,
	output wasc_status_t               status,
	output logic                       done,
	output logic [COUNT_W-1:0]         match_count,
	output logic                       is_query_answer,
	output logic                       store_full
);

	localparam int unsigned ADDR_W = $clog2(MAX_RECORDS);
	localparam int unsigned TOT_W  = $clog2(MAX_RECORDS + 1);
	localparam int unsigned REC_W  = 4 * KEY_BITS + SCORE_BITS;
	localparam logic [TOT_W-1:0] TOT_MAX = TOT_W'(MAX_RECORDS);

	// Captured transaction
	logic                  action_q;
	logic [KEY_BITS-1:0]   key_q [4];
	logic [SCORE_BITS-1:0] score_q;

	// Control registers
	logic [TOT_W-1:0]   total_q;
	logic [TOT_W-1:0]   addr_q;
	logic               valid_s1;
	logic [COUNT_W-1:0] count_q;
	logic               done_q;
	logic               is_query_q;
	logic               full_q;
	logic [COUNT_W-1:0] match_count_q;

	// Record memory and read data
	logic [REC_W-1:0] mem [MAX_RECORDS];
	logic [REC_W-1:0] rec_s1;

	logic full;
	logic match;

	assign full = (total_q == TOT_MAX);

	// Capture the transaction fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			key_q[0] <= key_first;
			key_q[1] <= key_second;
			key_q[2] <= key_third;
			key_q[3] <= key_fourth;
			score_q  <= score_value;
		end
	end

	// Write on add, read on scan
	always_ff @(posedge clk) begin
		if (cmd.add && !full) begin
			mem[total_q[ADDR_W-1:0]] <= {key_q[0], key_q[1], key_q[2], key_q[3], score_q};
		end
		if (cmd.scan_rd) begin
			rec_s1 <= mem[addr_q[ADDR_W-1:0]];
		end
	end

	// Compare the fetched record against the query
	always_comb begin
		logic [KEY_BITS-1:0] rk;
		match = (rec_s1[SCORE_BITS-1:0] >= score_q);
		for (int i = 0; i < 4; i++) begin
			rk = rec_s1[REC_W-1-i*KEY_BITS -: KEY_BITS];
			if (key_q[i] != '0 && key_q[i] != rk) begin
				match = 1'b0;
			end
		end
	end

	// Advance record total, scan address and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			addr_q   <= '0;
			valid_s1 <= 1'b0;
			count_q  <= '0;
		end else begin
			valid_s1 <= cmd.scan_rd;
			if (cmd.add && !full) begin
				total_q <= total_q + TOT_W'(1);
			end
			if (cmd.load) begin
				addr_q  <= '0;
				count_q <= '0;
			end else begin
				if (cmd.scan_rd) begin
					addr_q <= addr_q + TOT_W'(1);
				end
				if (valid_s1 && match && count_q != COUNT_MAX) begin
					count_q <= count_q + COUNT_W'(1);
				end
			end
		end
	end

	// Present one result per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q        <= 1'b0;
			is_query_q    <= 1'b0;
			full_q        <= 1'b0;
			match_count_q <= '0;
		end else begin
			done_q <= cmd.finish_add || cmd.finish_query;
			if (cmd.finish_add) begin
				is_query_q    <= 1'b0;
				full_q        <= full;
				match_count_q <= '0;
			end else if (cmd.finish_query) begin
				is_query_q    <= 1'b1;
				full_q        <= 1'b0;
				match_count_q <= count_q;
			end
		end
	end

	assign status.scan_end = (addr_q == total_q);
	assign done            = done_q;
	assign match_count     = match_count_q;
	assign is_query_answer = is_query_q;
	assign store_full      = full_q;

	// Record total never passes the store depth
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TOT_MAX)
		else $error("record total beyond store depth");

	// Scan never reads past the last stored record
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_rd |-> (addr_q < total_q))
		else $error("scan read beyond record total");

	// Record total only grows by one, and only on an add
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(total_q) |-> ($past(cmd.add) && total_q == $past(total_q) + TOT_W'(1)))
		else $error("record total changed unexpectedly");

	// Add acknowledgements carry no count; query answers never flag full
	a_result_form: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (is_query_q ? !full_q : (match_count_q == '0)))
		else $error("malformed result");

	// A query answer comes from a query transaction
	a_query_kind: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish_query |-> (action_q == ACT_QUERY))
		else $error("query answer for an add transaction");

endmodule

`default_nettype wire

>>> rtl/wildcard_attribute_score_count.sv
// Top level of the wildcard attribute score counter.
// Joins wasc_ctrl and wasc_dpath; uses wasc_pkg.
//
// Usage:
//   Drive start high with action, the four keys and score_value while busy is
//   low; the transaction is accepted at that clock edge. action 0 appends a
//   record (keys and score), action 1 counts stored records that equal every
//   non-zero query key and score at or above score_value.
//   Each transaction gives exactly one result: done is high for one cycle with
//   match_count, is_query_answer and store_full valid in that cycle. An add
//   on a full store stores nothing and reports store_full.
//   An add answers after its single write step. A query reads one
//   record per cycle through the single memory read port, so it answers
//   once all stored records are read and the last compare has landed in
//   the count. busy is low again in the cycle done is high, so a
//   new transaction may be accepted while the result is shown.
//   Reset empties the store at once (record total to zero); no clearing pass.
//   The receiver cannot stall: the result is shown for one cycle only.
`default_nettype none

module wildcard_attribute_score_count
	import wasc_pkg::*;
#(
	parameter int unsigned MAX_RECORDS = 1024,
	parameter int unsigned KEY_BITS    = 3,
	parameter int unsigned SCORE_BITS  = 20
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  action,
	input  wire logic [KEY_BITS-1:0]   key_first,
	input  wire logic [KEY_BITS-1:0]   key_second,
	input  wire logic [KEY_BITS-1:0]   key_third,
	input  wire logic [KEY_BITS-1:0]   key_fourth,
	input  wire logic [SCORE_BITS-1:0] score_value,
	output logic                       done,
	output logic [COUNT_W-1:0]         match_count,
	output logic                       is_query_answer,
	output logic                       store_full
);

	wasc_cmd_t    cmd;
	wasc_status_t status;

	wasc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	wasc_dpath #(
		.MAX_RECORDS (MAX_RECORDS),
		.KEY_BITS    (KEY_BITS),
		.SCORE_BITS  (SCORE_BITS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.action          (action),
		.key_first       (key_first),
		.key_second      (key_second),
		.key_third       (key_third),
		.key_fourth      (key_fourth),
		.score_value     (score_value),
		.status          (status),
		.done            (done),
		.match_count     (match_count),
		.is_query_answer (is_query_answer),
		.store_full      (store_full)
	);

endmodule

`default_nettype wire
